// File: sv/assert_macros.svh
// assertion macros for the stored-deflate png encoder
// clocked on i_clk, disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/psde_pkg.sv
// types, constants and crc rom for the stored-deflate png encoder
// no dependencies
package psde_pkg;

    localparam int DIM_W     = 12;
    localparam int RGB_W     = 24;
    localparam int RAW_W     = 32;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic FUNC_BEGIN = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 12'd512;

    localparam logic [63:0] PNG_SIG    = 64'h89504E470D0A1A0A;
    localparam logic [31:0] TYPE_IHDR  = 32'h49484452;
    localparam logic [31:0] TYPE_IDAT  = 32'h49444154;
    localparam logic [31:0] TYPE_IEND  = 32'h49454E44;
    localparam logic [31:0] IHDR_LEN   = 32'd13;
    localparam logic [7:0]  BIT_DEPTH  = 8'd8;
    localparam logic [7:0]  COLOR_TYPE = 8'd2;
    localparam logic [7:0]  ZLIB_CMF   = 8'h78;
    localparam logic [7:0]  ZLIB_FLG   = 8'h01;
    localparam logic [16:0] ADLER_MOD  = 17'd65521;
    localparam logic [15:0] BLK_MAX    = 16'hFFFF;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

    typedef struct packed {
        logic             func;
        logic [RGB_W-1:0] pixel_rgb;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_file;
    } t_out_item;

    typedef struct packed {
        logic             is_begin;
        logic             row_start;
        logic             is_last;
        logic [DIM_W-1:0] dim_w;
        logic [DIM_W-1:0] dim_h;
        logic [RGB_W-1:0] rgb;
    } t_cmd;

    typedef logic [31:0] t_crc_rom [256];

    function automatic t_crc_rom crc_rom_gen();
        t_crc_rom    t;
        logic [31:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 32'(i);
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            t[i] = c;
        end
        return t;
    endfunction

    localparam t_crc_rom CRC_ROM = crc_rom_gen();

    function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] i);
        return v[31 - 8 * i -: 8];
    endfunction

endpackage

// File: sv/psde_front.sv
// front end: config registers, item classification, frame counters
// depends on psde_pkg
module psde_front #(
    parameter int MAX_DIM = 2048
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [psde_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [psde_pkg::DIM_W-1:0]       i_cfg_data,
    input  logic                             i_accept,
    input  psde_pkg::t_in_item               i_item,
    output logic                             o_push,
    output psde_pkg::t_cmd                   o_cmd
);
    import psde_pkg::*;

    logic [DIM_W-1:0] r_img_w, r_img_h, n_img_w, n_img_h;
    logic [DIM_W-1:0] r_lat_w, r_lat_h, n_lat_w, n_lat_h;
    logic [DIM_W-1:0] r_col, r_row, n_col, n_row;
    logic             r_in_frame, n_in_frame;
    logic [DIM_W-1:0] clamp_w, clamp_h;
    logic             last_col, last_row;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0) return DIM_W'(1);
        if ({1'b0, v} > (DIM_W + 1)'(MAX_DIM)) return DIM_W'(MAX_DIM);
        return v;
    endfunction

    assign clamp_w  = clamp_dim(r_img_w);
    assign clamp_h  = clamp_dim(r_img_h);
    assign last_col = (r_col == r_lat_w - DIM_W'(1));
    assign last_row = (r_row == r_lat_h - DIM_W'(1));

    always_comb begin
        n_img_w    = r_img_w;
        n_img_h    = r_img_h;
        n_lat_w    = r_lat_w;
        n_lat_h    = r_lat_h;
        n_col      = r_col;
        n_row      = r_row;
        n_in_frame = r_in_frame;
        o_push     = 1'b0;
        o_cmd      = '0;
        o_cmd.rgb  = i_item.pixel_rgb;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  n_img_w = i_cfg_data;
                CFG_IMAGE_HEIGHT: n_img_h = i_cfg_data;
                default: ;
            endcase
        end
        if (i_accept) begin
            if (i_item.func == FUNC_BEGIN) begin
                o_push         = 1'b1;
                o_cmd.is_begin = 1'b1;
                o_cmd.dim_w    = clamp_w;
                o_cmd.dim_h    = clamp_h;
                n_lat_w        = clamp_w;
                n_lat_h        = clamp_h;
                n_col          = '0;
                n_row          = '0;
                n_in_frame     = 1'b1;
            end else if (r_in_frame) begin
                o_push          = 1'b1;
                o_cmd.row_start = (r_col == '0);
                o_cmd.is_last   = last_col && last_row;
                if (last_col) begin
                    n_col = '0;
                    n_row = r_row + DIM_W'(1);
                    if (last_row) n_in_frame = 1'b0;
                end else begin
                    n_col = r_col + DIM_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w    <= DIM_RESET;
            r_img_h    <= DIM_RESET;
            r_lat_w    <= DIM_W'(1);
            r_lat_h    <= DIM_W'(1);
            r_col      <= '0;
            r_row      <= '0;
            r_in_frame <= 1'b0;
        end else begin
            r_img_w    <= n_img_w;
            r_img_h    <= n_img_h;
            r_lat_w    <= n_lat_w;
            r_lat_h    <= n_lat_h;
            r_col      <= n_col;
            r_row      <= n_row;
            r_in_frame <= n_in_frame;
        end
    end

endmodule

// File: sv/psde_queue.sv
// short command queue between front and back
// depends on psde_pkg
module psde_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  psde_pkg::t_cmd               i_cmd,
    input  logic                         i_pop,
    output logic                         o_valid,
    output logic                         o_full,
    output logic [psde_pkg::Q_CNT_W-1:0] o_count,
    output psde_pkg::t_cmd               o_cmd
);
    import psde_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push, do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_count = r_cnt;
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= Q_PTR_W'((32'(r_wr) + 1) % Q_DEPTH);
            if (do_pop)  r_rd <= Q_PTR_W'((32'(r_rd) + 1) % Q_DEPTH);
            r_cnt <= r_cnt + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
        end
    end

endmodule

// File: sv/psde_back.sv
// back end: byte sequencer with crc-32, adler-32, stored block headers
// depends on psde_pkg
module psde_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  psde_pkg::t_cmd      i_q_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    output psde_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);
    import psde_pkg::*;

    typedef enum logic [3:0] {
        P_IDLE, P_SIG, P_IHDR_LEN, P_IHDR_TYPE, P_IHDR_DATA, P_IHDR_CRC,
        P_IDAT_LEN, P_IDAT_TYPE, P_ZHDR, P_RAW, P_ADLER, P_IDAT_CRC,
        P_IEND_LEN, P_IEND_TYPE, P_IEND_CRC
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [3:0]       r_idx, n_idx;
    logic [1:0]       r_ri, n_ri;
    t_cmd             r_cmd, n_cmd;
    logic [31:0]      r_crc, n_crc;
    logic [15:0]      r_lo, n_lo, r_hi, n_hi;
    logic [15:0]      r_blk, n_blk;
    logic [RAW_W-1:0] r_raw_left, n_raw_left;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic [13:0]      r_row_bytes;
    logic [RAW_W-1:0] r_raw, r_raw_d, r_zlen;
    logic [16:0]      r_nb;
    logic [RAW_W-1:0] t_sum;
    logic [16:0]      t_qr;

    logic             step, feed, fin_cmd;
    logic [7:0]       b;
    logic [31:0]      crc_out, adler;
    logic [15:0]      blk_n;
    logic [16:0]      lo1, lo2, hi1, hi2;

    always_ff @(posedge i_clk) begin
        r_row_bytes <= 14'd1 + 14'(r_cmd.dim_w) * 14'd3;
        r_raw       <= RAW_W'(r_cmd.dim_h) * RAW_W'(r_row_bytes);
        r_raw_d     <= r_raw;
        r_nb        <= 17'(t_sum[31:16]) + 17'(t_qr >= 17'(BLK_MAX));
        r_zlen      <= r_raw_d + RAW_W'(6) + RAW_W'(r_nb) * RAW_W'(5);
    end

    assign t_sum   = r_raw + RAW_W'(BLK_MAX) - RAW_W'(1);
    assign t_qr    = 17'(t_sum[31:16]) + 17'(t_sum[15:0]);
    assign crc_out = ~r_crc;
    assign adler   = {r_hi, r_lo};
    assign blk_n   = (r_raw_left > RAW_W'(BLK_MAX)) ? BLK_MAX : r_raw_left[15:0];
    assign step    = (r_phase != P_IDLE) && (!r_out_valid || !i_out_stall);
    assign lo1     = 17'(r_lo) + 17'(b);
    assign lo2     = (lo1 >= ADLER_MOD) ? lo1 - ADLER_MOD : lo1;
    assign hi1     = 17'(r_hi) + lo2;
    assign hi2     = (hi1 >= ADLER_MOD) ? hi1 - ADLER_MOD : hi1;

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_ri        = r_ri;
        n_cmd       = r_cmd;
        n_crc       = r_crc;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_blk       = r_blk;
        n_raw_left  = r_raw_left;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        b           = '0;
        feed        = 1'b0;
        fin_cmd     = 1'b0;
        if (!i_out_stall) n_out_valid = 1'b0;
        if (step) begin
            n_out_valid       = 1'b1;
            n_out.last_of_run = 1'b0;
            n_out.end_of_file = 1'b0;
            n_idx             = r_idx + 4'd1;
            unique case (r_phase)
                P_SIG: begin
                    b = PNG_SIG[63 - 8 * r_idx[2:0] -: 8];
                    if (r_idx == 4'd7) begin
                        n_phase = P_IHDR_LEN;
                        n_idx   = '0;
                    end
                end
                P_IHDR_LEN: begin
                    b = be_byte(IHDR_LEN, r_idx[1:0]);
                    if (r_idx == 4'd3) begin
                        n_phase = P_IHDR_TYPE;
                        n_idx   = '0;
                        n_crc   = CRC_PRESET;
                    end
                end
                P_IHDR_TYPE: begin
                    b    = be_byte(TYPE_IHDR, r_idx[1:0]);
                    feed = 1'b1;
                    if (r_idx == 4'd3) begin
                        n_phase = P_IHDR_DATA;
                        n_idx   = '0;
                    end
                end
                P_IHDR_DATA: begin
                    feed = 1'b1;
                    if (r_idx < 4'd4)       b = be_byte(32'(r_cmd.dim_w), r_idx[1:0]);
                    else if (r_idx < 4'd8)  b = be_byte(32'(r_cmd.dim_h), r_idx[1:0]);
                    else if (r_idx == 4'd8) b = BIT_DEPTH;
                    else if (r_idx == 4'd9) b = COLOR_TYPE;
                    if (r_idx == 4'd12) begin
                        n_phase = P_IHDR_CRC;
                        n_idx   = '0;
                    end
                end
                P_IHDR_CRC: begin
                    b = be_byte(crc_out, r_idx[1:0]);
                    if (r_idx == 4'd3) begin
                        n_phase = P_IDAT_LEN;
                        n_idx   = '0;
                    end
                end
                P_IDAT_LEN: begin
                    b = be_byte(r_zlen, r_idx[1:0]);
                    if (r_idx == 4'd3) begin
                        n_phase = P_IDAT_TYPE;
                        n_idx   = '0;
                        n_crc   = CRC_PRESET;
                    end
                end
                P_IDAT_TYPE: begin
                    b    = be_byte(TYPE_IDAT, r_idx[1:0]);
                    feed = 1'b1;
                    if (r_idx == 4'd3) begin
                        n_phase = P_ZHDR;
                        n_idx   = '0;
                    end
                end
                P_ZHDR: begin
                    b    = (r_idx == '0) ? ZLIB_CMF : ZLIB_FLG;
                    feed = 1'b1;
                    if (r_idx == 4'd1) begin
                        n_raw_left        = r_raw;
                        n_out.last_of_run = 1'b1;
                        fin_cmd           = 1'b1;
                        n_phase           = P_IDLE;
                    end
                end
                P_RAW: begin
                    feed = 1'b1;
                    if (r_blk == '0) begin
                        unique case (r_idx[2:0])
                            3'd0:    b = {7'd0, (r_raw_left <= RAW_W'(BLK_MAX))};
                            3'd1:    b = blk_n[7:0];
                            3'd2:    b = blk_n[15:8];
                            3'd3:    b = ~blk_n[7:0];
                            default: b = ~blk_n[15:8];
                        endcase
                        if (r_idx == 4'd4) begin
                            n_blk = blk_n;
                            n_idx = '0;
                        end
                    end else begin
                        n_idx = '0;
                        unique case (r_ri)
                            2'd0:    b = 8'd0;
                            2'd1:    b = r_cmd.rgb[23:16];
                            2'd2:    b = r_cmd.rgb[15:8];
                            default: b = r_cmd.rgb[7:0];
                        endcase
                        n_lo  = lo2[15:0];
                        n_hi  = hi2[15:0];
                        n_blk = r_blk - 16'd1;
                        if (r_raw_left != '0) n_raw_left = r_raw_left - RAW_W'(1);
                        n_ri = r_ri + 2'd1;
                        if (r_ri == 2'd3) begin
                            if (r_cmd.is_last) begin
                                n_phase = P_ADLER;
                            end else begin
                                n_out.last_of_run = 1'b1;
                                fin_cmd           = 1'b1;
                                n_phase           = P_IDLE;
                            end
                        end
                    end
                end
                P_ADLER: begin
                    b    = be_byte(adler, r_idx[1:0]);
                    feed = 1'b1;
                    if (r_idx == 4'd3) begin
                        n_phase = P_IDAT_CRC;
                        n_idx   = '0;
                    end
                end
                P_IDAT_CRC: begin
                    b = be_byte(crc_out, r_idx[1:0]);
                    if (r_idx == 4'd3) begin
                        n_phase = P_IEND_LEN;
                        n_idx   = '0;
                    end
                end
                P_IEND_LEN: begin
                    b = 8'd0;
                    if (r_idx == 4'd3) begin
                        n_phase = P_IEND_TYPE;
                        n_idx   = '0;
                        n_crc   = CRC_PRESET;
                    end
                end
                P_IEND_TYPE: begin
                    b    = be_byte(TYPE_IEND, r_idx[1:0]);
                    feed = 1'b1;
                    if (r_idx == 4'd3) begin
                        n_phase = P_IEND_CRC;
                        n_idx   = '0;
                    end
                end
                P_IEND_CRC: begin
                    b = be_byte(crc_out, r_idx[1:0]);
                    if (r_idx == 4'd3) begin
                        n_crc             = CRC_PRESET;
                        n_out.last_of_run = 1'b1;
                        n_out.end_of_file = 1'b1;
                        fin_cmd           = 1'b1;
                        n_phase           = P_IDLE;
                    end
                end
                default: ;
            endcase
            n_out.out_byte = b;
            if (feed) n_crc = CRC_ROM[r_crc[7:0] ^ b] ^ (r_crc >> 8);
        end
        o_pop = i_q_valid && ((r_phase == P_IDLE) || fin_cmd);
        if (o_pop) begin
            n_cmd = i_q_cmd;
            n_idx = '0;
            if (i_q_cmd.is_begin) begin
                n_phase = P_SIG;
                n_lo    = 16'd1;
                n_hi    = '0;
                n_blk   = '0;
            end else begin
                n_phase = P_RAW;
                n_ri    = i_q_cmd.row_start ? 2'd0 : 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= P_IDLE;
            r_idx       <= '0;
            r_ri        <= '0;
            r_cmd       <= '0;
            r_crc       <= CRC_PRESET;
            r_lo        <= 16'd1;
            r_hi        <= '0;
            r_blk       <= '0;
            r_raw_left  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_ri        <= n_ri;
            r_cmd       <= n_cmd;
            r_crc       <= n_crc;
            r_lo        <= n_lo;
            r_hi        <= n_hi;
            r_blk       <= n_blk;
            r_raw_left  <= n_raw_left;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: sv/png_stored_deflate_encoder.sv
// an accepted item goes through the queue and the sequencer state to the output register
// throughput: one byte per cycle from the output register unless i_out_stall holds it;
//   a pixel gives 3 bytes, 4 at a row start, 5 more at each stored block header,
//   20 more at image end; a begin item gives 43 bytes
// reset: synchronous active low, clears queue and sequencer, dimensions to 512 x 512
module png_stored_deflate_encoder #(
    parameter int MAX_DIM = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  psde_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output psde_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [psde_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [psde_pkg::DIM_W-1:0]     i_cfg_data
);
    import psde_pkg::*;
    `include "assert_macros.svh"

    logic               in_accept, q_push, q_pop, q_valid, q_full;
    logic [Q_CNT_W-1:0] q_count;
    t_cmd               f_cmd, q_cmd;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !o_in_stall;

    psde_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_item      (i_in_data),
        .o_push      (q_push),
        .o_cmd       (f_cmd)
    );

    psde_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_count (q_count),
        .o_cmd   (q_cmd)
    );

    psde_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    `ASSERT_SAME(a_q_bound, 1'b1, q_count <= Q_CNT_W'(Q_DEPTH), "queue count over depth")
    `ASSERT_SAME(a_no_lost_push, q_push, !q_full, "push into full queue")
    `ASSERT_SAME(a_eof_last, o_out_valid && o_out_data.end_of_file,
        o_out_data.last_of_run, "end of file without last of run")
    `ASSERT_NEXT(a_pop_full, q_full && !q_pop, q_full, "queue drained without pop")

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the stored-deflate png encoder
// depends on psde_pkg and png_stored_deflate_encoder; predicts every output byte
// and compares it beat by beat under random gaps and stalls on both channels
module testbench;
    import psde_pkg::*;

    localparam int WDOG_LIMIT = 20000;
    localparam int SETTLE     = 60;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DIM_W-1:0]     i_cfg_data = '0;

    png_stored_deflate_encoder u_top (.*);

    always #4 i_clk = ~i_clk;

    t_in_item  pixel_q[$];
    t_out_item png_byte_q[$];
    int        err_cnt = 0;
    int        idle_cyc = 0;
    int        in_gap = 0;
    bit        no_idle = 1'b0;
    int        n_images = 0, n_pixels = 0, n_bytes = 0, n_items = 0;

    // encoder model state
    logic [DIM_W-1:0] reg_w = DIM_RESET, reg_h = DIM_RESET;
    int unsigned lat_w = 1, lat_h = 1;
    bit          in_img = 1'b0;
    int unsigned col = 0, row = 0, blk_left = 0, raw_left = 0;
    int unsigned adl_lo = 1, adl_hi = 0;
    logic [31:0] crc = CRC_PRESET;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
        c ^= {24'd0, b};
        for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > 2048) return 2048;
        return v;
    endfunction

    task automatic emit(logic [7:0] b, bit with_crc);
        png_byte_q.push_back('{out_byte: b, last_of_run: 1'b0, end_of_file: 1'b0});
        if (with_crc) crc = crc_next(crc, b);
    endtask

    task automatic emit_be32(logic [31:0] v, bit with_crc);
        for (int s = 24; s >= 0; s -= 8) emit(v[s +: 8], with_crc);
    endtask

    task automatic emit_raw(logic [7:0] b);
        int unsigned n;
        if (blk_left == 0) begin
            n = (raw_left > 65535) ? 65535 : raw_left;
            emit((raw_left <= 65535) ? 8'd1 : 8'd0, 1'b1);
            emit(n[7:0], 1'b1);
            emit(n[15:8], 1'b1);
            emit(~n[7:0], 1'b1);
            emit(~n[15:8], 1'b1);
            blk_left = n;
        end
        emit(b, 1'b1);
        adl_lo += b;
        if (adl_lo >= 65521) adl_lo -= 65521;
        adl_hi += adl_lo;
        if (adl_hi >= 65521) adl_hi -= 65521;
        if (blk_left != 0) blk_left--;
        if (raw_left != 0) raw_left--;
    endtask

    task automatic encode_item(t_in_item it);
        int unsigned start, raw, nblk;
        start = png_byte_q.size();
        if (it.func == FUNC_BEGIN) begin
            lat_w = clamp_dim(reg_w);
            lat_h = clamp_dim(reg_h);
            emit_be32(PNG_SIG[63:32], 1'b0);
            emit_be32(PNG_SIG[31:0], 1'b0);
            emit_be32(32'd13, 1'b0);
            crc = CRC_PRESET;
            emit_be32(TYPE_IHDR, 1'b1);
            emit_be32(lat_w, 1'b1);
            emit_be32(lat_h, 1'b1);
            emit(8'd8, 1'b1);
            emit(8'd2, 1'b1);
            emit(8'd0, 1'b1);
            emit(8'd0, 1'b1);
            emit(8'd0, 1'b1);
            emit_be32(~crc, 1'b0);
            raw = lat_h * (1 + 3 * lat_w);
            nblk = (raw + 65534) / 65535;
            emit_be32(2 + nblk * 5 + raw + 4, 1'b0);
            crc = CRC_PRESET;
            emit_be32(TYPE_IDAT, 1'b1);
            emit(8'h78, 1'b1);
            emit(8'h01, 1'b1);
            in_img = 1'b1;
            col = 0;
            row = 0;
            blk_left = 0;
            raw_left = raw;
            adl_lo = 1;
            adl_hi = 0;
        end else if (in_img) begin
            if (col == 0) emit_raw(8'd0);
            emit_raw(it.pixel_rgb[23:16]);
            emit_raw(it.pixel_rgb[15:8]);
            emit_raw(it.pixel_rgb[7:0]);
            col++;
            if (col >= lat_w) begin
                col = 0;
                row++;
                if (row >= lat_h) begin
                    emit_be32({adl_hi[15:0], adl_lo[15:0]}, 1'b1);
                    emit_be32(~crc, 1'b0);
                    emit_be32(32'd0, 1'b0);
                    crc = CRC_PRESET;
                    emit_be32(TYPE_IEND, 1'b1);
                    emit_be32(~crc, 1'b0);
                    png_byte_q[png_byte_q.size()-1].end_of_file = 1'b1;
                    crc = CRC_PRESET;
                    in_img = 1'b0;
                end
            end
        end
        if (png_byte_q.size() > start) png_byte_q[png_byte_q.size()-1].last_of_run = 1'b1;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                encode_item(i_in_data);
                n_items++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    i_in_data  <= pixel_q.pop_front();
                    i_in_valid <= 1'b1;
                    in_gap = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                n_bytes++;
                if (png_byte_q.size() == 0) begin
                    $error("unexpected beat: out_byte %h", o_out_data.out_byte);
                    err_cnt++;
                end else begin
                    want = png_byte_q.pop_front();
                    if (o_out_data.out_byte !== want.out_byte) begin
                        $error("out_byte exp %h got %h", want.out_byte, o_out_data.out_byte);
                        err_cnt++;
                    end
                    if (o_out_data.last_of_run !== want.last_of_run) begin
                        $error("last_of_run exp %b got %b", want.last_of_run,
                               o_out_data.last_of_run);
                        err_cnt++;
                    end
                    if (o_out_data.end_of_file !== want.end_of_file) begin
                        $error("end_of_file exp %b got %b", want.end_of_file,
                               o_out_data.end_of_file);
                        err_cnt++;
                    end
                end
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)
                || (i_cfg_valid && o_cfg_ready))
                idle_cyc <= 0;
            else
                idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= WDOG_LIMIT) begin
                $display("timeout: %0d beats still expected", png_byte_q.size());
                $display("Verification failed");
                $finish;
            end
            i_out_stall <= (pick_gap() != 0);
        end
    end

    task automatic drain();
        do @(posedge i_clk);
        while (pixel_q.size() != 0 || i_in_valid || png_byte_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        if (idx == CFG_IMAGE_WIDTH) reg_w = val;
        else reg_h = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        cfg_write(CFG_IMAGE_WIDTH, w);
        cfg_write(CFG_IMAGE_HEIGHT, h);
    endtask

    task automatic push_item(logic func, logic [RGB_W-1:0] rgb);
        pixel_q.push_back('{func: func, pixel_rgb: rgb});
        if (func == FUNC_BEGIN) n_images++;
        else n_pixels++;
    endtask

    task automatic push_image(int unsigned npix, bit pause_mid);
        push_item(FUNC_BEGIN, RGB_W'($urandom()));
        for (int unsigned i = 0; i < npix; i++) begin
            if (pause_mid && i == npix / 2) drain();
            push_item(FUNC_PIXEL, RGB_W'($urandom()));
        end
    endtask

    initial begin
        int unsigned w, h, npix;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: stray pixel, abandoned default-size image, extremes, clamping
        push_item(FUNC_PIXEL, 24'hFFFFFF);
        push_item(FUNC_BEGIN, 24'h000000);
        push_item(FUNC_PIXEL, 24'hAAAAAA);
        push_item(FUNC_PIXEL, 24'h555555);
        drain();
        set_dims(12'd1, 12'd1);
        push_item(FUNC_BEGIN, 24'hFFFFFF);
        push_item(FUNC_PIXEL, 24'h000000);
        push_item(FUNC_PIXEL, 24'hFFFFFF);
        drain();
        set_dims(12'd0, 12'd0);
        push_item(FUNC_BEGIN, 24'd0);
        push_item(FUNC_PIXEL, 24'hFFFFFF);
        drain();
        set_dims(12'd3, 12'd2);
        push_item(FUNC_BEGIN, 24'd0);
        push_item(FUNC_PIXEL, 24'h123456);
        push_item(FUNC_BEGIN, 24'd0);
        for (int i = 0; i < 6; i++) push_item(FUNC_PIXEL, i[0] ? 24'hFFFFFF : 24'h000000);
        push_item(FUNC_PIXEL, 24'h808080);
        drain();

        // random small images
        while (n_items < 320) begin
            no_idle = ($urandom_range(4) == 0);
            w = $urandom_range(6, 1);
            h = $urandom_range(4, 1);
            set_dims(DIM_W'(w), DIM_W'(h));
            npix = w * h;
            if ($urandom_range(9) == 0) npix = $urandom_range(npix);
            push_image(npix, $urandom_range(7) == 0);
            if ($urandom_range(5) == 0) push_item(FUNC_PIXEL, RGB_W'($urandom()));
            drain();
        end
        no_idle = 1'b0;

        // partial large images: clamped and maximal dimensions, multi-block headers
        set_dims(12'd1, 12'hFFF);
        push_image(20, 1'b0);
        drain();
        set_dims(12'd2048, 12'd1);
        push_image(20, 1'b0);
        drain();
        set_dims(12'hFFF, 12'd11);
        push_image(40, 1'b1);
        drain();
        set_dims(12'd2, 12'd2048);
        push_image(20, 1'b0);
        drain();

        $display("ran %0d images with %0d pixel items, checked %0d output bytes",
                 n_images, n_pixels, n_bytes);
        $display("sizes from zero-clamped to over-range, including non-final stored blocks");
        if (err_cnt == 0 && png_byte_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/psde_pkg.sv
sv/psde_front.sv
sv/psde_queue.sv
sv/psde_back.sv
sv/png_stored_deflate_encoder.sv
tb/sv/testbench.sv
